FILE: hdl/tacs_pkg.sv
// Widths, constants and pipeline payload types of the touch calibration solver.
package tacs_pkg;

  localparam int CB    = 12;               // coordinate bits
  localparam int FB    = 16;               // fraction bits of a coefficient
  localparam int OUTW  = 32;               // coefficient width
  localparam int QB    = OUTW + 1;         // quotient bits, one extra for rounding
  localparam int SH    = QB - FB - 1;      // magnitude bits beyond the first remainder
  localparam int DW    = CB + 1;           // signed difference
  localparam int PW    = 2 * DW;           // product of two differences
  localparam int DTW   = PW + 1;           // determinant and gain numerators
  localparam int CW    = 2 * CB + 1;       // constant-term cofactor
  localparam int MW    = CB + 1 + CW;      // coordinate times cofactor
  localparam int NW    = MW + 2;           // any numerator
  localparam int CMPW  = (NW > DTW + SH) ? NW : DTW + SH;
  localparam int NLANE = 6;
  localparam int NST   = 7 + QB;           // register stages ahead of the output buffer
  localparam int INW   = 12 * CB;
  localparam int INDW  = ((INW + 7) / 8) * 8;
  localparam int OUTDW = NLANE * OUTW;

  localparam logic [QB-1:0] POS_MAX = QB'((64'd1 << (OUTW - 1)) - 64'd1);
  localparam logic [QB-1:0] NEG_MAX = QB'(64'd1 << (OUTW - 1));

  typedef struct packed {
    logic [DTW-1:0] rem;
    logic [QB-1:0]  xl;
    logic [QB-1:0]  q;
    logic           neg;
    logic           ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] ln;
    logic [DTW-1:0]    d;
    logic              ok;
  } dstg_t;

  typedef struct packed {
    logic                      solved;
    logic [NLANE-1:0][OUTW-1:0] coef;
  } res_t;

endpackage

FILE: hdl/touch_affine_calibration_solver.sv
// Three-point touchscreen affine calibration solver, fully pipelined.
// Pipeline: 7 arithmetic stages, 33 restoring divider stages, then one
// round/saturate step into the output buffer.
// Throughput: one point set per cycle while the output buffer is not full; six divider lanes run side by side.
// A two-entry output buffer lets the pipeline advance while a result waits.
// Reset (rst_n low, synchronous) clears stage valid bits and the buffer count.
module touch_affine_calibration_solver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // screen_x0, screen_y0, touch_i0, touch_j0, screen_x1, screen_y1, touch_i1,
  // touch_j1, screen_x2, screen_y2, touch_i2, touch_j2 (lowest bits first)
  input  logic [tacs_pkg::INDW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // gain_x_from_i, gain_x_from_j, offset_x, gain_y_from_i, gain_y_from_j,
  // offset_y (lowest bits first)
  output logic [tacs_pkg::OUTDW-1:0] out_tdata,
  // solved
  output logic                       out_tuser
);
  import tacs_pkg::*;

  // Global advance: taken from the registered buffer count only.
  logic           en;
  logic [NST-1:0] v_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  // Stage 1: captured fields
  logic [CB-1:0] s1_sx_r [3];
  logic [CB-1:0] s1_sy_r [3];
  logic [CB-1:0] s1_ti_r [3];
  logic [CB-1:0] s1_tj_r [3];

  // Stage 2: products
  logic signed [DW-1:0] di1, di2, dj1, dj2;
  logic signed [DW-1:0] ds1 [2];
  logic signed [DW-1:0] ds2 [2];
  logic signed [PW-1:0] s2_pda_r, s2_pdb_r;
  logic signed [PW-1:0] s2_pnaa_r [2];
  logic signed [PW-1:0] s2_pnab_r [2];
  logic signed [PW-1:0] s2_pnba_r [2];
  logic signed [PW-1:0] s2_pnbb_r [2];
  logic [2*CB-1:0]      s2_u_r [6];
  logic [CB-1:0]        s2_s_r [2][3];
  logic                 s2_fs_r;

  // Stage 3: determinant, gain numerators, cofactors
  logic signed [DTW-1:0] s3_det_r;
  logic signed [DTW-1:0] s3_na_r [2];
  logic signed [DTW-1:0] s3_nb_r [2];
  logic signed [CW-1:0]  s3_c_r [3];
  logic [CB-1:0]         s3_s_r [2][3];
  logic                  s3_fs_r;

  // Stage 4: constant-term products
  logic signed [MW-1:0]  s4_m_r [2][3];
  logic signed [DTW-1:0] s4_det_r;
  logic signed [DTW-1:0] s4_na_r [2];
  logic signed [DTW-1:0] s4_nb_r [2];
  logic                  s4_fs_r;

  // Stage 5: numerators in lane order A B C D E F
  logic signed [NW-1:0]  s5_num_r [NLANE];
  logic signed [DTW-1:0] s5_det_r;
  logic                  s5_ok_r;

  // Stage 6: magnitudes and signs
  logic [NW-1:0]    s6_mag_r [NLANE];
  logic             s6_neg_r [NLANE];
  logic [DTW-1:0]   s6_dm_r;
  logic             s6_ok_r;

  // Stage 7 and divider stages
  dstg_t dv_r   [QB+1];
  dstg_t dv_nxt [QB+1];

  res_t res, head_r, sk_r;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && v_r[NST-1];
  assign pop       = out_tvalid && out_tready;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  // Stage 1: capture the beat
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_sx_r[k] <= in_tdata[(4*k+0)*CB +: CB];
        s1_sy_r[k] <= in_tdata[(4*k+1)*CB +: CB];
        s1_ti_r[k] <= in_tdata[(4*k+2)*CB +: CB];
        s1_tj_r[k] <= in_tdata[(4*k+3)*CB +: CB];
      end
    end
  end

  // Stage 2: differences from the first point, then one multiply each
  always_comb begin
    di1 = $signed({1'b0, s1_ti_r[1]}) - $signed({1'b0, s1_ti_r[0]});
    di2 = $signed({1'b0, s1_ti_r[2]}) - $signed({1'b0, s1_ti_r[0]});
    dj1 = $signed({1'b0, s1_tj_r[1]}) - $signed({1'b0, s1_tj_r[0]});
    dj2 = $signed({1'b0, s1_tj_r[2]}) - $signed({1'b0, s1_tj_r[0]});
    ds1[0] = $signed({1'b0, s1_sx_r[1]}) - $signed({1'b0, s1_sx_r[0]});
    ds2[0] = $signed({1'b0, s1_sx_r[2]}) - $signed({1'b0, s1_sx_r[0]});
    ds1[1] = $signed({1'b0, s1_sy_r[1]}) - $signed({1'b0, s1_sy_r[0]});
    ds2[1] = $signed({1'b0, s1_sy_r[2]}) - $signed({1'b0, s1_sy_r[0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pda_r <= di1 * dj2;
      s2_pdb_r <= di2 * dj1;
      for (int a = 0; a < 2; a++) begin
        s2_pnaa_r[a] <= ds1[a] * dj2;
        s2_pnab_r[a] <= ds2[a] * dj1;
        s2_pnba_r[a] <= di1 * ds2[a];
        s2_pnbb_r[a] <= di2 * ds1[a];
      end
      s2_u_r[0] <= s1_ti_r[1] * s1_tj_r[2];
      s2_u_r[1] <= s1_ti_r[2] * s1_tj_r[1];
      s2_u_r[2] <= s1_ti_r[0] * s1_tj_r[2];
      s2_u_r[3] <= s1_ti_r[2] * s1_tj_r[0];
      s2_u_r[4] <= s1_ti_r[0] * s1_tj_r[1];
      s2_u_r[5] <= s1_ti_r[1] * s1_tj_r[0];
      for (int k = 0; k < 3; k++) begin
        s2_s_r[0][k] <= s1_sx_r[k];
        s2_s_r[1][k] <= s1_sy_r[k];
      end
      // all screen x equal, or all screen y equal: degenerate
      s2_fs_r <= (s1_sx_r[0] == s1_sx_r[1] && s1_sx_r[1] == s1_sx_r[2]) ||
                 (s1_sy_r[0] == s1_sy_r[1] && s1_sy_r[1] == s1_sy_r[2]);
    end
  end

  // Stage 3: subtract product pairs
  always_ff @(posedge clk) begin
    if (en) begin
      s3_det_r <= DTW'(s2_pda_r) - DTW'(s2_pdb_r);
      for (int a = 0; a < 2; a++) begin
        s3_na_r[a] <= DTW'(s2_pnaa_r[a]) - DTW'(s2_pnab_r[a]);
        s3_nb_r[a] <= DTW'(s2_pnba_r[a]) - DTW'(s2_pnbb_r[a]);
      end
      for (int k = 0; k < 3; k++) begin
        s3_c_r[k] <= $signed({1'b0, s2_u_r[2*k]}) - $signed({1'b0, s2_u_r[2*k+1]});
      end
      s3_s_r  <= s2_s_r;
      s3_fs_r <= s2_fs_r;
    end
  end

  // Stage 4: weight each cofactor by its screen coordinate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 3; k++) begin
          s4_m_r[a][k] <= $signed({1'b0, s3_s_r[a][k]}) * s3_c_r[k];
        end
      end
      s4_det_r <= s3_det_r;
      s4_na_r  <= s3_na_r;
      s4_nb_r  <= s3_nb_r;
      s4_fs_r  <= s3_fs_r;
    end
  end

  // Stage 5: constant-term numerators and the failure flag
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        s5_num_r[3*a+0] <= NW'(s4_na_r[a]);
        s5_num_r[3*a+1] <= NW'(s4_nb_r[a]);
        s5_num_r[3*a+2] <= NW'(s4_m_r[a][0]) - NW'(s4_m_r[a][1]) + NW'(s4_m_r[a][2]);
      end
      s5_det_r <= s4_det_r;
      s5_ok_r  <= !s4_fs_r && (s4_det_r != '0);
    end
  end

  // Stage 6: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        s6_mag_r[l] <= s5_num_r[l][NW-1] ? NW'(-s5_num_r[l]) : NW'(s5_num_r[l]);
        s6_neg_r[l] <= s5_num_r[l][NW-1] ^ s5_det_r[DTW-1];
      end
      s6_dm_r <= s5_det_r[DTW-1] ? DTW'(-s5_det_r) : DTW'(s5_det_r);
      s6_ok_r <= s5_ok_r;
    end
  end

  // Stage 7: overflow check and first remainder; then one quotient bit a stage
  always_comb begin
    logic [DTW:0] r2;
    logic         ge;
    dv_nxt[0].d  = s6_dm_r;
    dv_nxt[0].ok = s6_ok_r;
    for (int l = 0; l < NLANE; l++) begin
      // quotient of mag * 2^(FB+1) / d would need more than QB bits
      dv_nxt[0].ln[l].ovf = CMPW'(s6_mag_r[l]) >= (CMPW'(s6_dm_r) << SH);
      dv_nxt[0].ln[l].rem = DTW'(s6_mag_r[l] >> SH);
      dv_nxt[0].ln[l].xl  = {s6_mag_r[l][SH-1:0], {(FB+1){1'b0}}};
      dv_nxt[0].ln[l].q   = '0;
      dv_nxt[0].ln[l].neg = s6_neg_r[l];
    end
    for (int k = 1; k <= QB; k++) begin
      dv_nxt[k].d  = dv_r[k-1].d;
      dv_nxt[k].ok = dv_r[k-1].ok;
      for (int l = 0; l < NLANE; l++) begin
        r2 = {dv_r[k-1].ln[l].rem, dv_r[k-1].ln[l].xl[QB-1]};
        ge = r2 >= {1'b0, dv_r[k-1].d};
        dv_nxt[k].ln[l].rem = ge ? DTW'(r2 - {1'b0, dv_r[k-1].d}) : r2[DTW-1:0];
        dv_nxt[k].ln[l].xl  = {dv_r[k-1].ln[l].xl[QB-2:0], 1'b0};
        dv_nxt[k].ln[l].q   = {dv_r[k-1].ln[l].q[QB-2:0], ge};
        dv_nxt[k].ln[l].neg = dv_r[k-1].ln[l].neg;
        dv_nxt[k].ln[l].ovf = dv_r[k-1].ln[l].ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QB; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // Round half away from zero, saturate, zero everything on failure
  always_comb begin
    logic [QB:0]   tot1;
    logic [QB-1:0] tot;
    logic [QB-1:0] ntot;
    res.solved = dv_r[QB].ok;
    for (int l = 0; l < NLANE; l++) begin
      tot1 = {1'b0, dv_r[QB].ln[l].q} + (QB+1)'(1);
      tot  = tot1[QB:1];
      ntot = QB'(0) - tot;
      if (dv_r[QB].ln[l].neg) begin
        if (dv_r[QB].ln[l].ovf || tot > NEG_MAX) begin
          res.coef[l] = {1'b1, {(OUTW-1){1'b0}}};
        end else begin
          res.coef[l] = ntot[OUTW-1:0];
        end
      end else begin
        if (dv_r[QB].ln[l].ovf || tot > POS_MAX) begin
          res.coef[l] = {1'b0, {(OUTW-1){1'b1}}};
        end else begin
          res.coef[l] = tot[OUTW-1:0];
        end
      end
      if (!dv_r[QB].ok) begin
        res.coef[l] = '0;
      end
    end
  end

  // Two-entry output buffer: head drives the ports, the second beat waits behind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      head_r <= sk_r;
    end else if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      head_r <= res;
    end
    if (push && cnt_r == 2'd1 && !pop) begin
      sk_r <= res;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head_r.coef;
  assign out_tuser  = head_r.solved;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("unsolved result carries non-zero coefficients");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 && pop && !push |=> !out_tvalid)
    else $error("buffer shows a beat after draining");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && dv_r[QB].ok && !dv_r[QB].ln[0].ovf |-> dv_r[QB].ln[0].rem < dv_r[QB].d)
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: verif/touch_affine_calibration_solver_tb.sv
// Self-checking bench for the three-point touch calibration solver: directed and random point sets.
module touch_affine_calibration_solver_tb;
  import tacs_pkg::*;

  typedef struct {
    logic [11:0] sx[3];
    logic [11:0] sy[3];
    logic [11:0] ti[3];
    logic [11:0] tj[3];
  } cal_set_t;

  typedef struct {
    logic        solved;
    logic [31:0] coef[6];
  } cal_fit_t;

  // Directed row: the point set, plus a typed-in fit where it is obvious.
  typedef struct {
    cal_set_t pts;
    bit       known;
    cal_fit_t fit;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [INDW-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUTDW-1:0]     out_tdata;
  logic                 out_tuser;

  cal_fit_t fit_q[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       snd_idle_pct = 6;
  int       rcv_idle_pct = 77;
  bit       bench_done = 1'b0;

  localparam int WATCHDOG = 20000;

  touch_affine_calibration_solver uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round num * 2^16 / den half away from zero, then saturate to 32 bits.
  function automatic logic [31:0] q16_quot(longint num, longint den);
    bit neg;
    longint unsigned mag, d, q, r, total;
    neg = (num < 0) != (den < 0);
    mag = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = mag / d;
    r = mag % d;
    if (q > (64'd1 << 32)) total = 64'd1 << 40;
    else total = (q << 16) + (((r << 17) + d) / (d << 1));
    if (neg) begin
      if (total > (64'd1 << 31)) total = 64'd1 << 31;
      return 32'(-total);
    end
    if (total > (64'd1 << 31) - 1) total = (64'd1 << 31) - 1;
    return 32'(total);
  endfunction

  // Solve the affine map by Cramer's rule; degenerate sets give all zero.
  function automatic cal_fit_t solve_affine(cal_set_t p);
    cal_fit_t f;
    longint ti[3], tj[3], s[3];
    longint di1, di2, dj1, dj2, det, c0, c1, c2, ds1, ds2;
    f.solved = 1'b0;
    foreach (f.coef[k]) f.coef[k] = '0;
    for (int k = 0; k < 3; k++) begin
      ti[k] = p.ti[k];
      tj[k] = p.tj[k];
    end
    di1 = ti[1] - ti[0];
    di2 = ti[2] - ti[0];
    dj1 = tj[1] - tj[0];
    dj2 = tj[2] - tj[0];
    det = di1 * dj2 - di2 * dj1;
    if (p.sx[0] == p.sx[1] && p.sx[1] == p.sx[2]) return f;
    if (p.sy[0] == p.sy[1] && p.sy[1] == p.sy[2]) return f;
    if (det == 0) return f;
    c0 = ti[1] * tj[2] - ti[2] * tj[1];
    c1 = ti[0] * tj[2] - ti[2] * tj[0];
    c2 = ti[0] * tj[1] - ti[1] * tj[0];
    f.solved = 1'b1;
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 3; k++) s[k] = a == 0 ? longint'(p.sx[k]) : longint'(p.sy[k]);
      ds1 = s[1] - s[0];
      ds2 = s[2] - s[0];
      f.coef[3*a]   = q16_quot(ds1 * dj2 - ds2 * dj1, det);
      f.coef[3*a+1] = q16_quot(di1 * ds2 - di2 * ds1, det);
      f.coef[3*a+2] = q16_quot(s[0] * c0 - s[1] * c1 + s[2] * c2, det);
    end
    return f;
  endfunction

  // Field-by-field comparison of two fits.
  function automatic bit fit_eq(cal_fit_t a, cal_fit_t b);
    bit same;
    same = a.solved === b.solved;
    for (int k = 0; k < 6; k++) same &= (a.coef[k] === b.coef[k]);
    return same;
  endfunction

  function automatic logic [INDW-1:0] pack_set(cal_set_t p);
    logic [INDW-1:0] v;
    v = '0;
    for (int k = 0; k < 3; k++) begin
      v[(4*k)*12 +: 12]   = p.sx[k];
      v[(4*k+1)*12 +: 12] = p.sy[k];
      v[(4*k+2)*12 +: 12] = p.ti[k];
      v[(4*k+3)*12 +: 12] = p.tj[k];
    end
    return v;
  endfunction

  function automatic cal_set_t unpack_in(logic [INDW-1:0] v);
    cal_set_t p;
    for (int k = 0; k < 3; k++) begin
      p.sx[k] = v[(4*k)*12 +: 12];
      p.sy[k] = v[(4*k+1)*12 +: 12];
      p.ti[k] = v[(4*k+2)*12 +: 12];
      p.tj[k] = v[(4*k+3)*12 +: 12];
    end
    return p;
  endfunction

  function automatic cal_set_t mk_set(int x0, int y0, int i0, int j0, int x1, int y1,
                                      int i1, int j1, int x2, int y2, int i2, int j2);
    cal_set_t p;
    p.sx = '{12'(x0), 12'(x1), 12'(x2)};
    p.sy = '{12'(y0), 12'(y1), 12'(y2)};
    p.ti = '{12'(i0), 12'(i1), 12'(i2)};
    p.tj = '{12'(j0), 12'(j1), 12'(j2)};
    return p;
  endfunction

  // Half the time a plausible touch panel: a noisy, scaled version of the screen points.
  function automatic cal_set_t rand_set();
    cal_set_t p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      p.sx[k] = 12'($urandom);
      p.sy[k] = 12'($urandom);
      p.ti[k] = 12'($urandom);
      p.tj[k] = 12'($urandom);
      if (mode < 5) begin
        p.ti[k] = 12'((p.sx[k] >> $urandom_range(0, 2)) + $urandom_range(0, 300));
        p.tj[k] = 12'((p.sy[k] >> $urandom_range(0, 2)) + $urandom_range(0, 300));
      end else if (mode == 5) begin
        p.ti[k] = 12'($urandom_range(1000, 1003));
      end
    end
    case (mode)
      6: p.sx[2] = p.sx[0];
      7: begin p.ti[2] = p.ti[1]; p.tj[2] = p.tj[1]; end
      8: begin p.sx[1] = p.sx[0]; p.sx[2] = p.sx[0]; end
      9: begin p.sy[1] = p.sy[0]; p.sy[2] = p.sy[0]; end
      default: ;
    endcase
    return p;
  endfunction

  // Hold the beat until accepted; idle beforehand at the sender's rate.
  task automatic send_set(cal_set_t p);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_set(p);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Queue the expectation at the accepting edge so it is ahead of its result.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) fit_q.push_back(solve_affine(unpack_in(in_tdata)));
  end

  // Receiver: random stall, compare each result beat with the oldest fit.
  always @(posedge clk) begin
    cal_fit_t e;
    bit bad;
    out_tready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (fit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, solved=%0b", out_tuser);
      end else begin
        e = fit_q.pop_front();
        bad = out_tuser !== e.solved;
        for (int k = 0; k < 6; k++) bad |= out_tdata[k*32 +: 32] !== e.coef[k];
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: solved exp %0b got %0b", e.solved, out_tuser);
            for (int k = 0; k < 6; k++)
              $display("  coef %0d exp %h got %h", k, e.coef[k], out_tdata[k*32 +: 32]);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (rst_n && !bench_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t row;
    cal_fit_t zero_fit, unit_fit;
    int tail;
    zero_fit.solved = 1'b0;
    foreach (zero_fit.coef[k]) zero_fit.coef[k] = '0;
    // Identity map: touch equals screen, so gains are 1.0 and offsets zero.
    unit_fit = zero_fit;
    unit_fit.solved = 1'b1;
    unit_fit.coef[0] = 32'h0001_0000;
    unit_fit.coef[4] = 32'h0001_0000;

    // Degenerate cases: fixed zero fit.
    dir_rows.push_back('{mk_set(5, 1, 0, 0, 5, 2, 100, 0, 5, 3, 0, 100), 1, zero_fit});
    dir_rows.push_back('{mk_set(1, 7, 0, 0, 2, 7, 100, 0, 3, 7, 0, 100), 1, zero_fit});
    dir_rows.push_back('{mk_set(0, 0, 9, 9, 4095, 0, 9, 9, 0, 4095, 9, 9), 1, zero_fit});
    dir_rows.push_back('{mk_set(0, 0, 0, 0, 10, 5, 1, 1, 20, 9, 2, 2), 1, zero_fit});
    dir_rows.push_back('{mk_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_fit});
    dir_rows.push_back('{mk_set(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                                4095, 4095, 4095, 4095), 1, zero_fit});
    // Identity at the field extremes.
    dir_rows.push_back('{mk_set(0, 0, 0, 0, 4095, 0, 4095, 0, 0, 4095, 0, 4095), 1, unit_fit});
    dir_rows.push_back('{mk_set(4095, 4095, 4095, 4095, 0, 4095, 0, 4095, 4095, 0, 4095, 0),
                         1, unit_fit});
    // Large gains of both signs, half-rounding and all-ones coverage via predictor.
    dir_rows.push_back('{mk_set(0, 0, 0, 0, 4095, 4095, 1, 0, 0, 4095, 0, 1), 0, zero_fit});
    dir_rows.push_back('{mk_set(4095, 0, 0, 0, 0, 4095, 1, 0, 4095, 4095, 0, 1), 0, zero_fit});
    dir_rows.push_back('{mk_set(0, 0, 0, 0, 1, 1, 2, 0, 0, 1, 0, 2), 0, zero_fit});
    dir_rows.push_back('{mk_set(1, 2, 4095, 0, 3, 5, 0, 4095, 4095, 1, 4094, 4095), 0, zero_fit});
    dir_rows.push_back('{mk_set(2730, 1365, 1, 4094, 1365, 2730, 4094, 1, 7, 9, 3, 3), 0, zero_fit});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      row = dir_rows[n];
      if (row.known && !fit_eq(solve_affine(row.pts), row.fit)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predictor disagrees with typed-in fit", n);
      end
      send_set(row.pts);
    end

    // Three idling phases: sender light/receiver heavy, swapped, then none.
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = ph == 0 ? 6 : ph == 1 ? 77 : 0;
      rcv_idle_pct = ph == 0 ? 77 : ph == 1 ? 6 : 0;
      repeat (ph == 2 ? 620 : 610) send_set(rand_set());
    end
    in_tvalid <= 1'b0;

    while (fit_q.size() != 0) @(posedge clk);
    bench_done = 1'b1;
    tail = 0;
    while (tail < 100) begin
      @(posedge clk);
      tail++;
    end
    if (mismatches == 0 && fit_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
